### hdl/spct_pkg.sv
package spct_pkg;

  // pair kinds carried on the action field
  typedef enum logic [2:0] {
    ACT_BOX_BOX   = 3'd0,
    ACT_BOX_CIRC  = 3'd1,
    ACT_BOX_SEG   = 3'd2,
    ACT_CIRC_CIRC = 3'd3,
    ACT_CIRC_SEG  = 3'd4,
    ACT_SEG_SEG   = 3'd5
  } action_t;

  // sign of an orientation cross product: zero, or positive when not zero
  typedef struct packed {
    logic zero;
    logic pos;
  } orient_t;

  // segment-segment tests run per pair: four orientation jobs per pair
  localparam int NUM_PAIRS = 4;
  localparam int NUM_JOBS  = 4 * NUM_PAIRS;

endpackage

### hdl/shape_pair_collision_test.sv
// Shape pair collision test. Each request names a pair kind and the geometry of
// two shapes (boxes, circles, segments) in signed fixed point and returns one hit
// bit. The block is a fully pipelined datapath of eight register stages: a
// request is taken in every cycle (busy stays low) and its result appears on hit
// with done high at the output of the final register stage, in request order.
// The depth is set by the circle-segment test, whose final compare of two
// products of squared values is built from split partial products over two
// stages. The receiver cannot stall: done is high for one cycle only.
module shape_pair_collision_test import spct_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   action,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_p,
  input  logic signed [COORD_BITS-1:0] a_q,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_p,
  input  logic signed [COORD_BITS-1:0] b_q,
  output logic                         hit,
  output logic                         done
);

  localparam int W  = COORD_BITS;
  localparam int P  = W + 2;        // doubled points and box extents
  localparam int P1 = P + 1;        // differences of points
  localparam int MO = 2 * P1;       // orientation products
  localparam int C1 = W + 1;        // differences of plain coordinates
  localparam int MC = 2 * C1;       // products of those
  localparam int CW = 2 * W + 1;    // magnitudes for the final circle-segment compare
  localparam int H  = W + 1;        // low part of a split operand
  localparam int HH = CW - H;       // high part

  assign busy = 1'b0;

  function automatic logic in_span(input logic signed [P-1:0] px, input logic signed [P-1:0] py,
                                   input logic signed [P-1:0] qx, input logic signed [P-1:0] qy,
                                   input logic signed [P-1:0] rx, input logic signed [P-1:0] ry);
    logic signed [P-1:0] xmax, xmin, ymax, ymin;
    xmax = (px > rx) ? px : rx;
    xmin = (px < rx) ? px : rx;
    ymax = (py > ry) ? py : ry;
    ymin = (py < ry) ? py : ry;
    return (qx <= xmax) && (qx >= xmin) && (qy <= ymax) && (qy >= ymin);
  endfunction

  // ---------------- stage 1: capture request, box extents ----------------
  logic                v1;
  action_t             act1;
  logic signed [W-1:0] ax1, ay1, ap1, aq1, bx1, by1, bp1, bq1;
  logic signed [P-1:0] cxl1, cxh1, cyl1, cyh1, bxl1, bxh1, byl1, byh1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      act1 <= action_t'(action);
      ax1  <= a_x;
      ay1  <= a_y;
      ap1  <= a_p;
      aq1  <= a_q;
      bx1  <= b_x;
      by1  <= b_y;
      bp1  <= b_p;
      bq1  <= b_q;
      cxl1 <= (P'(a_x) <<< 1) - P'(a_p);
      cxh1 <= (P'(a_x) <<< 1) + P'(a_p);
      cyl1 <= (P'(a_y) <<< 1) - P'(a_q);
      cyh1 <= (P'(a_y) <<< 1) + P'(a_q);
      bxl1 <= (P'(b_x) <<< 1) - P'(b_p);
      bxh1 <= (P'(b_x) <<< 1) + P'(b_p);
      byl1 <= (P'(b_y) <<< 1) - P'(b_q);
      byh1 <= (P'(b_y) <<< 1) + P'(b_q);
    end
  end

  // ---------------- stage 2: points, differences, compares ----------------
  logic signed [P-1:0]  sx, sy, ex, ey;
  logic signed [P-1:0]  e0x [NUM_PAIRS];
  logic signed [P-1:0]  e0y [NUM_PAIRS];
  logic signed [P-1:0]  e1x [NUM_PAIRS];
  logic signed [P-1:0]  e1y [NUM_PAIRS];
  logic signed [P-1:0]  jpx [NUM_JOBS];
  logic signed [P-1:0]  jpy [NUM_JOBS];
  logic signed [P-1:0]  jqx [NUM_JOBS];
  logic signed [P-1:0]  jqy [NUM_JOBS];
  logic signed [P-1:0]  jrx [NUM_JOBS];
  logic signed [P-1:0]  jry [NUM_JOBS];
  logic signed [P1-1:0] d1_next [NUM_JOBS];
  logic signed [P1-1:0] d2_next [NUM_JOBS];
  logic signed [P1-1:0] d3_next [NUM_JOBS];
  logic signed [P1-1:0] d4_next [NUM_JOBS];
  logic                 span_next [NUM_JOBS];
  logic signed [P-1:0]  xc, yc, xn, yn;
  logic signed [P1-1:0] ddx_next, ddy_next;

  always_comb begin
    sx = P'(bx1) <<< 1;
    sy = P'(by1) <<< 1;
    ex = P'(bp1) <<< 1;
    ey = P'(bq1) <<< 1;
    // box edges in order around the box
    e0x[0] = cxl1; e0y[0] = cyh1; e1x[0] = cxh1; e1y[0] = cyh1;
    e0x[1] = cxh1; e0y[1] = cyh1; e1x[1] = cxh1; e1y[1] = cyl1;
    e0x[2] = cxh1; e0y[2] = cyl1; e1x[2] = cxl1; e1y[2] = cyl1;
    e0x[3] = cxl1; e0y[3] = cyl1; e1x[3] = cxl1; e1y[3] = cyh1;
    // segment pair: first segment against the second one on pair 0
    if (act1 == ACT_SEG_SEG) begin
      sx = P'(ax1) <<< 1;
      sy = P'(ay1) <<< 1;
      ex = P'(ap1) <<< 1;
      ey = P'(aq1) <<< 1;
      e0x[0] = P'(bx1) <<< 1;
      e0y[0] = P'(by1) <<< 1;
      e1x[0] = P'(bp1) <<< 1;
      e1y[0] = P'(bq1) <<< 1;
    end
    for (int k = 0; k < NUM_PAIRS; k++) begin
      jpx[4*k]   = sx;     jpy[4*k]   = sy;     jqx[4*k]   = ex;     jqy[4*k]   = ey;
      jrx[4*k]   = e0x[k]; jry[4*k]   = e0y[k];
      jpx[4*k+1] = sx;     jpy[4*k+1] = sy;     jqx[4*k+1] = ex;     jqy[4*k+1] = ey;
      jrx[4*k+1] = e1x[k]; jry[4*k+1] = e1y[k];
      jpx[4*k+2] = e0x[k]; jpy[4*k+2] = e0y[k]; jqx[4*k+2] = e1x[k]; jqy[4*k+2] = e1y[k];
      jrx[4*k+2] = sx;     jry[4*k+2] = sy;
      jpx[4*k+3] = e0x[k]; jpy[4*k+3] = e0y[k]; jqx[4*k+3] = e1x[k]; jqy[4*k+3] = e1y[k];
      jrx[4*k+3] = ex;     jry[4*k+3] = ey;
    end
    for (int j = 0; j < NUM_JOBS; j++) begin
      d1_next[j]   = P1'(jqy[j]) - P1'(jpy[j]);
      d2_next[j]   = P1'(jrx[j]) - P1'(jqx[j]);
      d3_next[j]   = P1'(jqx[j]) - P1'(jpx[j]);
      d4_next[j]   = P1'(jry[j]) - P1'(jqy[j]);
      span_next[j] = in_span(jpx[j], jpy[j], jrx[j], jry[j], jqx[j], jqy[j]);
    end
    // box point nearest the circle centre
    xc = P'(bx1) <<< 1;
    yc = P'(by1) <<< 1;
    xn = (xc < cxh1) ? xc : cxh1;
    yn = (yc < cyh1) ? yc : cyh1;
    if (xn < cxl1) xn = cxl1;
    if (yn < cyl1) yn = cyl1;
    ddx_next = P1'(xn) - P1'(xc);
    ddy_next = P1'(yn) - P1'(yc);
  end

  logic                 v2;
  action_t              act2;
  logic signed [P1-1:0] d1_2 [NUM_JOBS];
  logic signed [P1-1:0] d2_2 [NUM_JOBS];
  logic signed [P1-1:0] d3_2 [NUM_JOBS];
  logic signed [P1-1:0] d4_2 [NUM_JOBS];
  logic                 span2 [NUM_JOBS];
  logic                 inside2, bb2;
  logic signed [P1-1:0] ddx2, ddy2;
  logic signed [W-1:0]  br2, ar2;
  logic signed [C1-1:0] rs2, cdx2, cdy2, sdx2, sdy2, wx2, wy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    act2 <= act1;
    for (int j = 0; j < NUM_JOBS; j++) begin
      d1_2[j]  <= d1_next[j];
      d2_2[j]  <= d2_next[j];
      d3_2[j]  <= d3_next[j];
      d4_2[j]  <= d4_next[j];
      span2[j] <= span_next[j];
    end
    inside2 <= (sx >= cxl1) && (sx <= cxh1) && (sy >= cyl1) && (sy <= cyh1);
    bb2     <= (cxh1 >= bxl1) && (cxl1 <= bxh1) && (cyh1 >= byl1) && (cyl1 <= byh1);
    ddx2    <= ddx_next;
    ddy2    <= ddy_next;
    br2     <= bp1;
    ar2     <= ap1;
    rs2     <= C1'(ap1) + C1'(bp1);
    cdx2    <= C1'(ax1) - C1'(bx1);
    cdy2    <= C1'(ay1) - C1'(by1);
    sdx2    <= C1'(bp1) - C1'(bx1);
    sdy2    <= C1'(bq1) - C1'(by1);
    wx2     <= C1'(ax1) - C1'(bp1);
    wy2     <= C1'(ay1) - C1'(bq1);
  end

  // ---------------- stage 3: products ----------------
  logic                   v3;
  action_t                act3;
  logic signed [MO-1:0]   om1_3 [NUM_JOBS];
  logic signed [MO-1:0]   om2_3 [NUM_JOBS];
  logic                   span3 [NUM_JOBS];
  logic                   inside3, bb3, rs_neg3;
  logic signed [MO-1:0]   qx3, qy3;
  logic signed [2*W-1:0]  qr3, r2_3;
  logic signed [MC-1:0]   rsq3, cdx_sq3, cdy_sq3, t1_3, t2_3, l1_3, l2_3, x1_3, x2_3;
  logic signed [MC-1:0]   wx_sq3, wy_sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    act3 <= act2;
    for (int j = 0; j < NUM_JOBS; j++) begin
      om1_3[j] <= MO'(d1_2[j]) * MO'(d2_2[j]);
      om2_3[j] <= MO'(d3_2[j]) * MO'(d4_2[j]);
      span3[j] <= span2[j];
    end
    inside3 <= inside2;
    bb3     <= bb2;
    rs_neg3 <= rs2[C1-1];
    qx3     <= MO'(ddx2) * MO'(ddx2);
    qy3     <= MO'(ddy2) * MO'(ddy2);
    qr3     <= (2*W)'(br2) * (2*W)'(br2);
    r2_3    <= (2*W)'(ar2) * (2*W)'(ar2);
    rsq3    <= MC'(rs2) * MC'(rs2);
    cdx_sq3 <= MC'(cdx2) * MC'(cdx2);
    cdy_sq3 <= MC'(cdy2) * MC'(cdy2);
    t1_3    <= MC'(cdx2) * MC'(sdx2);
    t2_3    <= MC'(cdy2) * MC'(sdy2);
    l1_3    <= MC'(sdx2) * MC'(sdx2);
    l2_3    <= MC'(sdy2) * MC'(sdy2);
    x1_3    <= MC'(cdx2) * MC'(sdy2);
    x2_3    <= MC'(cdy2) * MC'(sdx2);
    wx_sq3  <= MC'(wx2) * MC'(wx2);
    wy_sq3  <= MC'(wy2) * MC'(wy2);
  end

  // ---------------- stage 4: orientation signs, sums and compares ----------------
  logic signed [MO:0] ov [NUM_JOBS];
  logic signed [MC:0] vv_sum, ww_sum, cc_sum;

  always_comb begin
    for (int j = 0; j < NUM_JOBS; j++) begin
      ov[j] = (MO+1)'(om1_3[j]) - (MO+1)'(om2_3[j]);
    end
    vv_sum = (MC+1)'(cdx_sq3) + (MC+1)'(cdy_sq3);
    ww_sum = (MC+1)'(wx_sq3) + (MC+1)'(wy_sq3);
    cc_sum = vv_sum;
  end

  logic               v4;
  action_t            act4;
  orient_t            or4 [NUM_JOBS];
  logic               span4 [NUM_JOBS];
  logic               inside4, bb4, bc4, cc4, vv_ok4, ww_ok4;
  logic signed [MC:0] t4, len4, cross4;
  logic [CW-1:0]      r2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    act4 <= act3;
    for (int j = 0; j < NUM_JOBS; j++) begin
      or4[j].zero <= (ov[j] == 0);
      or4[j].pos  <= (ov[j] > 0);
      span4[j]    <= span3[j];
    end
    inside4 <= inside3;
    bb4     <= bb3;
    bc4     <= ((MO+1)'(qx3) + (MO+1)'(qy3)) <= ((MO+1)'(qr3) <<< 2);
    cc4     <= !rs_neg3 && ((MC+1)'(rsq3) >= cc_sum);
    vv_ok4  <= vv_sum <= (MC+1)'(r2_3);
    ww_ok4  <= ww_sum <= (MC+1)'(r2_3);
    t4      <= (MC+1)'(t1_3) + (MC+1)'(t2_3);
    len4    <= (MC+1)'(l1_3) + (MC+1)'(l2_3);
    cross4  <= (MC+1)'(x1_3) - (MC+1)'(x2_3);
    r2_4    <= CW'($unsigned(r2_3));
  end

  // ---------------- stage 5: segment decisions, early results ----------------
  logic               pair_hit [NUM_PAIRS];
  logic               box_seg_hit;
  logic               hit5_next;
  logic signed [MC:0] cross_mag;

  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      pair_hit[k] = ((or4[4*k] != or4[4*k+1]) && (or4[4*k+2] != or4[4*k+3])) ||
                    (or4[4*k].zero   && span4[4*k])   ||
                    (or4[4*k+1].zero && span4[4*k+1]) ||
                    (or4[4*k+2].zero && span4[4*k+2]) ||
                    (or4[4*k+3].zero && span4[4*k+3]);
    end
    box_seg_hit = pair_hit[0] || pair_hit[1] || pair_hit[2] || pair_hit[3] || inside4;
    unique case (act4)
      ACT_BOX_BOX:   hit5_next = bb4;
      ACT_BOX_CIRC:  hit5_next = bc4;
      ACT_BOX_SEG:   hit5_next = box_seg_hit;
      ACT_CIRC_CIRC: hit5_next = cc4;
      ACT_SEG_SEG:   hit5_next = pair_hit[0];
      default:       hit5_next = 1'b0;
    endcase
    cross_mag = cross4[MC] ? -cross4 : cross4;
  end

  logic          v5, hit5, is_cs5, dec5, res5;
  logic [CW-1:0] cm5, r2_5, len5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  // nearest point is an endpoint when the projection falls outside the segment
  always_ff @(posedge clk) begin
    hit5   <= hit5_next;
    is_cs5 <= (act4 == ACT_CIRC_SEG);
    dec5   <= (t4 <= 0) || (t4 >= len4);
    res5   <= (t4 <= 0) ? vv_ok4 : ww_ok4;
    cm5    <= cross_mag[CW-1:0];
    r2_5   <= r2_4;
    len5   <= len4[CW-1:0];
  end

  // ---------------- stage 6: split partial products ----------------
  logic             v6, hit6, is_cs6, dec6, res6;
  logic [2*H-1:0]   cll6, rll6;
  logic [H+HH-1:0]  clh6, rlh6, rhl6;
  logic [2*HH-1:0]  chh6, rhh6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    hit6   <= hit5;
    is_cs6 <= is_cs5;
    dec6   <= dec5;
    res6   <= res5;
    cll6   <= (2*H)'(cm5[H-1:0]) * (2*H)'(cm5[H-1:0]);
    clh6   <= (H+HH)'(cm5[H-1:0]) * (H+HH)'(cm5[CW-1:H]);
    chh6   <= (2*HH)'(cm5[CW-1:H]) * (2*HH)'(cm5[CW-1:H]);
    rll6   <= (2*H)'(r2_5[H-1:0]) * (2*H)'(len5[H-1:0]);
    rlh6   <= (H+HH)'(r2_5[H-1:0]) * (H+HH)'(len5[CW-1:H]);
    rhl6   <= (H+HH)'(r2_5[CW-1:H]) * (H+HH)'(len5[H-1:0]);
    rhh6   <= (2*HH)'(r2_5[CW-1:H]) * (2*HH)'(len5[CW-1:H]);
  end

  // ---------------- stage 7: assemble squared cross and r^2 * len^2 ----------------
  logic            v7, hit7, is_cs7, dec7, res7;
  logic [2*CW:0]   csq7, rsq7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    hit7   <= hit6;
    is_cs7 <= is_cs6;
    dec7   <= dec6;
    res7   <= res6;
    csq7   <= ((2*CW+1)'(chh6) << (2*H)) + ((2*CW+1)'(clh6) << (H+1)) + (2*CW+1)'(cll6);
    rsq7   <= ((2*CW+1)'(rhh6) << (2*H)) + (((2*CW+1)'(rlh6) + (2*CW+1)'(rhl6)) << H) +
              (2*CW+1)'(rll6);
  end

  // ---------------- stage 8: final select ----------------
  logic hit_next;

  always_comb begin
    hit_next = hit7;
    if (is_cs7) begin
      hit_next = dec7 ? res7 : (csq7 <= rsq7);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    hit <= hit_next;
  end

endmodule
